// ===== design/ntcth_pkg.sv =====
// Shared types and constants for the thermistor table temperature unit.
`default_nettype none

package ntcth_pkg;

  // Fixed field widths of the item formats.
  localparam int unsigned TempW  = 7;
  localparam int unsigned IndexW = 7;
  localparam int unsigned FaultW = 2;

  // Temperature reported for a shorted sensor, and the ceiling of a step.
  localparam logic [TempW-1:0] ShortTemp = 7'd100;
  localparam logic [TempW-1:0] TempMax   = 7'd127;

  // Operation carried in the input tuser bit.
  localparam logic OpSample = 1'b0;
  localparam logic OpWrite  = 1'b1;

  typedef enum logic [FaultW-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_OPEN  = 2'd1,
    FAULT_SHORT = 2'd2
  } fault_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted beat, write the table on a write item
    logic scan;    // step the table search
    logic finish;  // commit the new temperature into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // search found its candidate this cycle
    logic out_busy;   // output register holds a beat that is not taken
  } status_t;

endpackage

`default_nettype wire

// ===== design/ntcth_ctrl.sv =====
// Controller state machine that sequences load, table search and result.
`default_nettype none

module ntcth_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_op_i,
  input  wire ntcth_pkg::status_t status_i,
  output ntcth_pkg::cmd_t       cmd_o,
  output logic                  in_ready_o
);

  ntcth_pkg::state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ntcth_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_op_i == ntcth_pkg::OpWrite) ? ntcth_pkg::ST_DONE
                                                    : ntcth_pkg::ST_SCAN;
        end
      end
      ntcth_pkg::ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ntcth_pkg::ST_DONE;
        end
      end
      ntcth_pkg::ST_DONE: begin
        if (!status_i.out_busy) begin
          state_d = ntcth_pkg::ST_IDLE;
        end
      end
      default: state_d = ntcth_pkg::ST_IDLE;
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ntcth_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      ntcth_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ntcth_pkg::ST_DONE: begin
        cmd_o.finish = !status_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ntcth_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/ntcth_datapath.sv =====
// Datapath: calibration table memory, pipelined search, hysteresis and output register.
`default_nettype none

module ntcth_datapath #(
  parameter int unsigned TABLE_DEPTH = 100,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire ntcth_pkg::cmd_t                    cmd_i,
  input  wire logic                               op_i,
  input  wire logic [SAMPLE_BITS-1:0]             sample_i,
  input  wire logic [ntcth_pkg::IndexW-1:0]       entry_index_i,
  input  wire logic [SAMPLE_BITS-1:0]             entry_value_i,
  input  wire logic                               out_ready_i,
  output ntcth_pkg::status_t                      status_o,
  output logic                                    out_valid_o,
  output logic [ntcth_pkg::TempW-1:0]             temperature_o,
  output ntcth_pkg::fault_e                       fault_o
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CmpW  = 8;
  localparam int unsigned DiffW = SAMPLE_BITS + 1;
  localparam int unsigned ThW   = SAMPLE_BITS + 2;
  localparam logic [CmpW-1:0] DepthC = CmpW'(TABLE_DEPTH);
  localparam logic [CntW-1:0] LastIdx = CntW'(TABLE_DEPTH - 1);

  logic [SAMPLE_BITS-1:0] mem_q [TABLE_DEPTH];

  logic                        op_q;
  logic [SAMPLE_BITS-1:0]      sample_q;
  logic [CntW-1:0]             idx_q;
  logic                        rvalid_q;
  logic [CntW-1:0]             ridx_q;
  logic [SAMPLE_BITS-1:0]      rdata_q;
  logic [SAMPLE_BITS-1:0]      last_q;
  logic [SAMPLE_BITS-1:0]      below_q;
  logic [SAMPLE_BITS-1:0]      lo_q;
  logic [SAMPLE_BITS-1:0]      hi_q;
  logic [CntW-1:0]             cand_q;
  logic [ntcth_pkg::TempW-1:0] cur_q;
  logic                        out_valid_q;
  logic [ntcth_pkg::TempW-1:0] out_temp_q;
  ntcth_pkg::fault_e           out_fault_q;

  logic                        rd_en;
  logic                        hit;
  logic                        ended;
  logic                        wr_en;
  logic [CmpW-1:0]             ridx_w;
  logic [CmpW-1:0]             cur_w;
  logic [CmpW-1:0]             cur_p1;
  logic [CmpW-1:0]             cand_w;
  logic [CmpW-1:0]             cand_p1;
  logic                        up_move;
  logic [SAMPLE_BITS-1:0]      base_a;
  logic [SAMPLE_BITS-1:0]      base_b;
  logic signed [DiffW-1:0]     diff;
  logic signed [DiffW-1:0]     diff_adj;
  logic signed [DiffW-1:0]     quarter;
  logic signed [ThW-1:0]       thresh;
  logic signed [ThW-1:0]       sample_s;
  logic [ntcth_pkg::TempW-1:0] temp_d;
  ntcth_pkg::fault_e           fault_d;

  // Table writes; an index past the table is dropped.
  assign wr_en = cmd_i.load && (op_i == ntcth_pkg::OpWrite)
                 && ({1'b0, entry_index_i} < DepthC);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[entry_index_i[AddrW-1:0]] <= entry_value_i;
    end
  end

  // One table read per cycle during the search, data registered.
  assign rd_en = cmd_i.scan && (idx_q < CntW'(TABLE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[idx_q[AddrW-1:0]];
    end
  end

  // Search pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rvalid_q <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= rd_en;
      if (rd_en) begin
        idx_q <= idx_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      ridx_q <= idx_q;
    end
  end

  assign ridx_w = CmpW'(ridx_q);
  assign cur_w  = CmpW'(cur_q);
  assign cur_p1 = cur_w + CmpW'(1);

  // The first entry above the sample ends the search; so does the last entry.
  assign hit   = cmd_i.scan && rvalid_q && (sample_q < rdata_q);
  assign ended = cmd_i.scan && rvalid_q && !hit && (ridx_q == LastIdx);

  assign status_o.scan_done = hit || ended;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  // Capture the item and the entries that the hysteresis step needs.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      sample_q <= sample_i;
    end
    if (cmd_i.scan && rvalid_q) begin
      last_q  <= rdata_q;
      below_q <= last_q;
      if (ridx_w == cur_w) begin
        lo_q <= rdata_q;
      end
      if (ridx_w == cur_p1) begin
        hi_q <= rdata_q;
      end
    end
    if (hit) begin
      cand_q <= ridx_q;
    end else if (ended) begin
      cand_q <= CntW'(TABLE_DEPTH);
    end
  end

  // Quarter-step threshold, rounded toward zero.
  assign cand_w  = CmpW'(cand_q);
  assign cand_p1 = cand_w + CmpW'(1);
  assign up_move = cand_w > cur_w;
  assign base_a  = up_move ? hi_q : last_q;
  assign base_b  = up_move ? lo_q : below_q;
  assign diff     = $signed({1'b0, base_a}) - $signed({1'b0, base_b});
  assign diff_adj = diff + (diff[DiffW-1] ? DiffW'(3) : DiffW'(0));
  assign quarter  = diff_adj >>> 2;
  assign sample_s = $signed({2'b00, sample_q});
  assign thresh   = up_move
                    ? $signed({2'b00, lo_q}) + ThW'(quarter)
                    : $signed({2'b00, last_q}) - ThW'(quarter);

  // New temperature and fault for the finished item.
  always_comb begin
    temp_d  = cur_q;
    fault_d = ntcth_pkg::FAULT_NONE;
    if (op_q == ntcth_pkg::OpSample) begin
      if (cand_w == '0) begin
        temp_d  = '0;
        fault_d = ntcth_pkg::FAULT_OPEN;
      end else if (cand_w >= DepthC) begin
        temp_d  = ntcth_pkg::ShortTemp;
        fault_d = ntcth_pkg::FAULT_SHORT;
      end else if (up_move) begin
        temp_d = (sample_s >= thresh) ? ntcth_pkg::TempW'(cand_w)
                                      : ntcth_pkg::TempW'(cand_w - CmpW'(1));
      end else if (cand_w < cur_w) begin
        if (sample_s <= thresh) begin
          temp_d = ntcth_pkg::TempW'(cand_w);
        end else if (cand_p1 > CmpW'(ntcth_pkg::TempMax)) begin
          temp_d = ntcth_pkg::TempMax;
        end else begin
          temp_d = ntcth_pkg::TempW'(cand_p1);
        end
      end
    end
  end

  // Temperature state and output beat valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      cur_q       <= temp_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_temp_q  <= temp_d;
      out_fault_q <= fault_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign temperature_o = out_temp_q;
  assign fault_o       = out_fault_q;

`ifndef SYNTH
  // A result is never committed over a beat that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(out_valid_q && !out_ready_i))
    else $error("result committed over a pending output beat");

  // Returned read data always comes from an entry inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> (ridx_q < CntW'(TABLE_DEPTH)))
    else $error("table read outside its depth");

  // A shorted sample leaves the temperature at the short value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && (fault_d == ntcth_pkg::FAULT_SHORT)) |=>
      (cur_q == ntcth_pkg::ShortTemp))
    else $error("short fault without short temperature");

  // A write item never reports a fault.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && (op_q == ntcth_pkg::OpWrite)) |=>
      (out_fault_q == ntcth_pkg::FAULT_NONE))
    else $error("fault reported for a table write");
`endif

endmodule

`default_nettype wire

// ===== design/ntc_table_temperature_hysteresis_unit.sv =====
// Top level of the thermistor table temperature unit with hysteresis.
//
//  Channel | Direction | tdata (low bit up)                      | tuser
//  s_axis  | in        | sample, entry_index, entry_value, zeros | op (0 sample, 1 write)
//  m_axis  | out       | temperature, zero                       | fault
//
// A write beat writes the table on acceptance and then commits its result. A
// sample beat first runs the search, which reads one table entry per cycle from
// the calibration memory until an entry above the sample or the last entry.
// Reset clears the current temperature and the control; the table holds no
// reset value and must be written before samples are sent.
// A new beat is accepted while the previous result waits in the output register.
`default_nettype none

module ntc_table_temperature_hysteresis_unit #(
  parameter int unsigned TABLE_DEPTH = 100,
  parameter int unsigned SAMPLE_BITS = 10,
  localparam int unsigned InW = 2 * SAMPLE_BITS + 1 + ntcth_pkg::IndexW - 1,
  localparam int unsigned InTdataW = ((InW + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // sample, entry_index, entry_value, zero fill
  input  wire logic [InTdataW-1:0]   s_axis_tdata,
  // op
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // temperature, zero fill
  output logic [7:0]                 m_axis_tdata,
  // fault
  output logic [1:0]                 m_axis_tuser
);

  ntcth_pkg::cmd_t                 cmd;
  ntcth_pkg::status_t              status;
  logic [SAMPLE_BITS-1:0]          in_sample;
  logic [ntcth_pkg::IndexW-1:0]    in_index;
  logic [SAMPLE_BITS-1:0]          in_value;
  logic [ntcth_pkg::TempW-1:0]     temperature;
  ntcth_pkg::fault_e               fault;

  // Unpack the input beat.
  assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_index  = s_axis_tdata[SAMPLE_BITS +: ntcth_pkg::IndexW];
  assign in_value  = s_axis_tdata[SAMPLE_BITS + ntcth_pkg::IndexW +: SAMPLE_BITS];

  ntcth_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  ntcth_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (s_axis_tuser),
    .sample_i      (in_sample),
    .entry_index_i (in_index),
    .entry_value_i (in_value),
    .out_ready_i   (m_axis_tready),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid),
    .temperature_o (temperature),
    .fault_o       (fault)
  );

  // Pack the output beat.
  assign m_axis_tdata = {1'b0, temperature};
  assign m_axis_tuser = fault;

endmodule

`default_nettype wire
